// ===== rtl/fwdp_pkg.sv =====
`default_nettype none

package fwdp_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 4;
	localparam int CHAR_W  = 8;
	localparam int DD_BITS = 5;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_ERR  = 8'h45;

	typedef enum logic {
		CMD_DIGITS = 1'b0,
		CMD_ERR    = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [VALUE_W-1:0]   value;
		logic [COUNT_W-1:0]   count;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/fwdp_if.sv =====
`default_nettype none

interface fwdp_in_if;
	import fwdp_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic [COUNT_W-1:0] digit_count;
	modport source(output valid, value, digit_count, input ready);
	modport sink(input valid, value, digit_count, output ready);
endinterface

interface fwdp_out_if;
	import fwdp_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ascii_char;
	logic              last;
	modport source(output valid, ascii_char, last, input ready);
	modport sink(input valid, ascii_char, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/fwdp_front.sv =====
`default_nettype none

module fwdp_front #(
	parameter int MAX_DIGITS = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	fwdp_in_if.sink         din,
	output logic            q_valid,
	output fwdp_pkg::cmd_t  q_cmd,
	input  logic            q_pop
);
	import fwdp_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	cmd_t       new_cmd;

	assign din.ready = (fill_q != 2'd2);
	assign push      = din.valid && din.ready && (din.digit_count != '0);
	assign pop       = q_pop && q_valid;
	assign q_valid   = (fill_q != 2'd0);
	assign q_cmd     = slot_q[rd_ptr_q];

	always_comb begin
		new_cmd.kind  = (din.digit_count > COUNT_W'(MAX_DIGITS)) ? CMD_ERR : CMD_DIGITS;
		new_cmd.value = din.value;
		new_cmd.count = din.digit_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= new_cmd;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("queue fill out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd0 || fill_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with fill");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/fwdp_back.sv =====
`default_nettype none

module fwdp_back #(
	parameter int MAX_DIGITS = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  fwdp_pkg::cmd_t  q_cmd,
	output logic            q_pop,
	fwdp_out_if.source      dout
);
	import fwdp_pkg::*;

	localparam int BCD_W  = 4 * MAX_DIGITS;
	localparam int STEPS  = (VALUE_W + DD_BITS - 1) / DD_BITS;
	localparam int BIN_W  = STEPS * DD_BITS;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int LEFT_W = $clog2(MAX_DIGITS + 1);
	localparam int SH_W   = $clog2(BCD_W);

	typedef enum logic [2:0] {
		CV_IDLE = 3'b001,
		CV_RUN  = 3'b010,
		CV_DONE = 3'b100
	} cv_state_t;

	cv_state_t          cv_state_q;
	cv_state_t          cv_state_n;
	logic [STEP_W-1:0]  cv_step_q;
	logic [BIN_W-1:0]   cv_bin_q;
	logic [BCD_W-1:0]   cv_bcd_q;
	logic [BCD_W-1:0]   bcd_n;
	cmd_kind_t          cv_kind_q;
	logic [COUNT_W-1:0] cv_count_q;

	logic               em_valid_q;
	logic               em_err_q;
	logic [LEFT_W-1:0]  em_left_q;
	logic [BCD_W-1:0]   em_dig_q;
	logic [SH_W-1:0]    em_shift;

	logic em_free;
	logic em_load;
	logic cv_take;
	logic last_step;
	logic out_xfer;

	assign out_xfer  = dout.valid && dout.ready;
	assign em_free   = !em_valid_q || (dout.ready && em_left_q == LEFT_W'(1));
	assign em_load   = (cv_state_q == CV_DONE) && em_free;
	assign cv_take   = (cv_state_q == CV_IDLE) || em_load;
	assign q_pop     = q_valid && cv_take;
	assign last_step = (cv_step_q == STEP_W'(STEPS - 1));
	assign em_shift  = SH_W'(BCD_W - 4 * int'(cv_count_q));

	// shift-and-add-3, DD_BITS bits per cycle, low digits only
	always_comb begin
		bcd_n = cv_bcd_q;
		for (int b = 0; b < DD_BITS; b++) begin
			for (int d = 0; d < MAX_DIGITS; d++) begin
				if (bcd_n[4*d +: 4] >= 4'd5)
					bcd_n[4*d +: 4] = bcd_n[4*d +: 4] + 4'd3;
			end
			bcd_n = {bcd_n[BCD_W-2:0], cv_bin_q[BIN_W-1-b]};
		end
	end

	always_comb begin
		cv_state_n = cv_state_q;
		unique case (cv_state_q)
			CV_IDLE: begin
				if (q_valid)
					cv_state_n = (q_cmd.kind == CMD_ERR) ? CV_DONE : CV_RUN;
			end
			CV_RUN: begin
				if (last_step)
					cv_state_n = CV_DONE;
			end
			CV_DONE: begin
				if (em_free) begin
					if (q_valid)
						cv_state_n = (q_cmd.kind == CMD_ERR) ? CV_DONE : CV_RUN;
					else
						cv_state_n = CV_IDLE;
				end
			end
			default: cv_state_n = CV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_state_q <= CV_IDLE;
			cv_step_q  <= '0;
			em_valid_q <= 1'b0;
			em_left_q  <= '0;
		end else begin
			cv_state_q <= cv_state_n;
			if (q_pop)
				cv_step_q <= '0;
			else if (cv_state_q == CV_RUN)
				cv_step_q <= cv_step_q + STEP_W'(1);
			if (em_load) begin
				em_valid_q <= 1'b1;
				em_left_q  <= (cv_kind_q == CMD_ERR) ? LEFT_W'(1) : LEFT_W'(cv_count_q);
			end else if (out_xfer) begin
				em_left_q <= em_left_q - LEFT_W'(1);
				if (em_left_q == LEFT_W'(1))
					em_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cv_kind_q  <= q_cmd.kind;
			cv_count_q <= q_cmd.count;
			cv_bin_q   <= BIN_W'(q_cmd.value);
			cv_bcd_q   <= '0;
		end else if (cv_state_q == CV_RUN) begin
			cv_bin_q <= cv_bin_q << DD_BITS;
			cv_bcd_q <= bcd_n;
		end
		if (em_load) begin
			em_err_q <= (cv_kind_q == CMD_ERR);
			em_dig_q <= cv_bcd_q << em_shift;
		end else if (out_xfer) begin
			em_dig_q <= em_dig_q << 4;
		end
	end

	assign dout.valid      = em_valid_q;
	assign dout.ascii_char = em_err_q ? ASCII_ERR
		: (ASCII_ZERO + {{(CHAR_W-4){1'b0}}, em_dig_q[BCD_W-1 -: 4]});
	assign dout.last       = (em_left_q == LEFT_W'(1));

	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		em_valid_q |-> (em_left_q != '0))
		else $error("emitter valid with no characters left");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(em_valid_q && em_err_q) |-> (em_left_q == LEFT_W'(1)))
		else $error("error mark spans more than one character");

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		((cv_state_q == CV_DONE) && !em_free) |=> (cv_state_q == CV_DONE) && em_valid_q)
		else $error("converted item dropped while emitter busy");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cv_state_q == CV_RUN) |-> (cv_step_q <= STEP_W'(STEPS - 1)))
		else $error("conversion step counter overran");

endmodule

`default_nettype wire

// ===== rtl/fixed_width_decimal_printer.sv =====
`default_nettype none

// channel | dir | fields                   | transfer
// din     | in  | value[31:0], digit_count | valid && ready
// dout    | out | ascii_char[7:0], last    | valid && ready
//
// Conversion runs 5 binary bits per cycle, then hands each digit item off
// into the emitter. The emitter gives one character per cycle while dout
// is ready; an error item is a single character. A two-entry queue
// lets input accept while the converter and emitter work, and the
// converter starts the next item while the emitter sends the last.
// Items with a zero count are accepted and dropped in the front part.
// Reset clears the queue, converter and emitter; no clearing pass.

module fixed_width_decimal_printer #(
	parameter int MAX_DIGITS = 7
) (
	input  logic       clk,
	input  logic       arst_n,
	fwdp_in_if.sink    din,
	fwdp_out_if.source dout
);
	import fwdp_pkg::*;

	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	fwdp_front #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	fwdp_back #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.dout    (dout)
	);

endmodule

`default_nettype wire
